// ===== rtl/image_rotate_address_generator_core_defines.svh =====
// assertion macros shared by the rotate address generator rtl
// no dependencies; files that check their own logic include this header
`ifndef IMAGE_ROTATE_ADDRESS_GENERATOR_CORE_DEFINES_SVH
`define IMAGE_ROTATE_ADDRESS_GENERATOR_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property must hold at every edge outside reset
`define IRAG_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define IRAG_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define IRAG_ASSERT(label, clk, rst, prop, msg)

`define IRAG_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

// ===== rtl/irag_pkg.sv =====
// shared types and constants of the rotate address generator
// no dependencies
`default_nettype none

package irag_pkg;

   localparam int PIXEL_W    = 32;
   localparam int OFFSET_W   = 26;
   localparam int SIDE_REG_W = 13;
   localparam int ROT_W      = 2;
   localparam int BPP_W      = 3;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 2;

   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 4;
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROTATION_MODE   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd3;

   // rotation codes
   localparam logic [ROT_W-1:0] ROT_NONE = 2'd0;
   localparam logic [ROT_W-1:0] ROT_90   = 2'd1;
   localparam logic [ROT_W-1:0] ROT_180  = 2'd2;
   localparam logic [ROT_W-1:0] ROT_270  = 2'd3;

   // status codes
   localparam logic STATUS_OK          = 1'b0;
   localparam logic STATUS_UNSUPPORTED = 1'b1;

   // reset values
   localparam logic [SIDE_REG_W-1:0] WIDTH_RESET  = 13'd1;
   localparam logic [SIDE_REG_W-1:0] HEIGHT_RESET = 13'd1;
   localparam logic [BPP_W-1:0]      BPP_RESET    = 3'd4;
   localparam logic [BPP_W-1:0]      BPP_MAX      = 3'd4;

   typedef struct packed {
      logic [OFFSET_W-1:0] dest_offset;
      logic [PIXEL_W-1:0]  pixel_out;
      logic                last_pixel;
      logic                status;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== rtl/image_rotate_address_generator_core.sv =====
// Rotation address generator for a raster pixel stream.
// Input queue side: present req_pixel_in with push; it is taken on a clock edge
// where push is high and full is low. Pixels arrive in raster order.
// Result queue side: while empty is low the oldest result sits on the rsp_ ports;
// pop on a clock edge with empty low takes it. Each pixel gives one result:
// destination byte offset for 90, 180 or 270 degree rotation, the pixel
// unchanged, a last-pixel flag and a status (1 when rotation mode is 0).
// Registers are written through csr_we/csr_index/csr_wdata; the user must write
// them only while the block is idle, which the block itself does not enforce;
// every write restarts the frame at the first pixel. Throughput: one pixel per
// clock while pop keeps the result queue drained. Each pixel passes through the
// input queue, the multiply stage and the add stage ahead of the result queue.
// Reset (synchronous, active high) empties both queues, zeroes the raster
// counters and loads width 1, height 1, rotate 90 and 4 bytes per pixel.
// When pop stays low the four-entry result queue fills, the back end stops,
// the four-entry input queue fills behind it and full goes high; nothing is
// dropped and flow resumes at full rate once pop returns.
// Depends on irag_pkg, irag_fifo, irag_front and irag_back.
`default_nettype none

module image_rotate_address_generator_core #(
   parameter int MAX_SIDE = 4096
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [irag_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [irag_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                            push,
   output logic                                 full,
   input  wire logic [irag_pkg::PIXEL_W-1:0]    req_pixel_in,
   output logic                                 empty,
   input  wire logic                            pop,
   output logic      [irag_pkg::OFFSET_W-1:0]   rsp_dest_offset,
   output logic      [irag_pkg::PIXEL_W-1:0]    rsp_pixel_out,
   output logic                                 rsp_last_pixel,
   output logic                                 rsp_status
);

   import irag_pkg::*;

   localparam int XW      = $clog2(MAX_SIDE);
   localparam int SW      = $clog2(MAX_SIDE + 1);
   localparam int ENTRY_W = PIXEL_W + 2 * XW + SW + BPP_W + 2;
   localparam int RSP_W   = $bits(rsp_item_type);
   localparam int MID_CW  = $clog2(MID_DEPTH + 1);

   logic               mid_push;
   logic [ENTRY_W-1:0] mid_wr_data;
   logic               mid_pop;
   logic [ENTRY_W-1:0] mid_rd_data;
   logic               mid_full;
   logic               mid_empty;
   logic [MID_CW-1:0]  mid_count;

   logic                 out_push;
   rsp_item_type         out_item;
   logic [RSP_W-1:0]     out_wr_data;
   logic [RSP_W-1:0]     out_rd_data;
   logic                 out_full;
   logic                 out_empty;
   logic [OUT_CNT_W-1:0] out_count;
   logic                 out_pop;
   rsp_item_type         rsp_item;

   irag_front #(
      .MAX_SIDE (MAX_SIDE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .push      (push),
      .pixel_in  (req_pixel_in),
      .q_full    (mid_full),
      .q_push    (mid_push),
      .q_data    (mid_wr_data)
   );

   irag_fifo #(
      .WIDTH (ENTRY_W),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mid_push),
      .wr_data (mid_wr_data),
      .rd_en   (mid_pop),
      .rd_data (mid_rd_data),
      .full    (mid_full),
      .empty   (mid_empty),
      .count   (mid_count)
   );

   irag_back #(
      .MAX_SIDE (MAX_SIDE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_data    (mid_rd_data),
      .q_empty   (mid_empty),
      .q_pop     (mid_pop),
      .out_count (out_count),
      .out_push  (out_push),
      .out_data  (out_item)
   );

   assign out_wr_data = out_item;
   assign out_pop     = pop && !out_empty;

   irag_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (out_push),
      .wr_data (out_wr_data),
      .rd_en   (out_pop),
      .rd_data (out_rd_data),
      .full    (out_full),
      .empty   (out_empty),
      .count   (out_count)
   );

   assign rsp_item        = out_rd_data;
   assign full            = mid_full || (mid_count > MID_CW'(MID_DEPTH)) || (out_full && 1'b0);
   assign empty           = out_empty;
   assign rsp_dest_offset = rsp_item.dest_offset;
   assign rsp_pixel_out   = rsp_item.pixel_out;
   assign rsp_last_pixel  = rsp_item.last_pixel;
   assign rsp_status      = rsp_item.status;

endmodule

`default_nettype wire

// ===== rtl/irag_fifo.sv =====
// small register queue with occupancy count
// generic; used between front and back and at the result side
`default_nettype none
`include "image_rotate_address_generator_core_defines.svh"

module irag_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       wr_en,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic                       rd_en,
   output logic      [WIDTH-1:0]           rd_data,
   output logic                            full,
   output logic                            empty,
   output logic      [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff;
   logic [PW-1:0]    rd_ptr_in;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + CW'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = mem_ff[rd_ptr_ff];
   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;

   `IRAG_ASSERT_NEVER(a_fifo_no_overflow, clock, reset, wr_en && full && !rd_en, "queue overflow")
   `IRAG_ASSERT_NEVER(a_fifo_no_underflow, clock, reset, rd_en && empty, "queue underflow")

endmodule

`default_nettype wire

// ===== rtl/irag_front.sv =====
// front end: registers, raster counters and per-pixel rotation terms
// depends on irag_pkg; feeds the middle queue
`default_nettype none
`include "image_rotate_address_generator_core_defines.svh"

module irag_front #(
   parameter  int MAX_SIDE = 4096,
   localparam int XW       = $clog2(MAX_SIDE),
   localparam int SW       = $clog2(MAX_SIDE + 1),
   localparam int ENTRY_W  = irag_pkg::PIXEL_W + 2 * XW + SW + irag_pkg::BPP_W + 2
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [irag_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [irag_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                            push,
   input  wire logic [irag_pkg::PIXEL_W-1:0]    pixel_in,
   input  wire logic                            q_full,
   output logic                                 q_push,
   output logic      [ENTRY_W-1:0]              q_data
);

   import irag_pkg::*;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic [XW-1:0]      fa;
      logic [SW-1:0]      fb;
      logic [XW-1:0]      fc;
      logic [BPP_W-1:0]   bpp;
      logic               last;
      logic               status;
   } entry_type;

   logic [SIDE_REG_W-1:0] width_ff;
   logic [SIDE_REG_W-1:0] height_ff;
   logic [ROT_W-1:0]      rot_ff;
   logic [BPP_W-1:0]      bpp_ff;
   logic [XW-1:0]         col_ff;
   logic [XW-1:0]         col_in;
   logic [XW-1:0]         row_ff;
   logic [XW-1:0]         row_in;

   logic [SW-1:0]    w_eff;
   logic [SW-1:0]    h_eff;
   logic [BPP_W-1:0] b_eff;
   logic [XW-1:0]    w_m1;
   logic [XW-1:0]    h_m1;
   logic             last_col;
   logic             last;
   logic             accept;
   entry_type        entry;

   // clamp sides to 1..MAX_SIDE and pixel size to 1..4
   always_comb begin
      if (width_ff == '0) begin
         w_eff = SW'(1);
      end else if (32'(width_ff) > 32'(MAX_SIDE)) begin
         w_eff = SW'(MAX_SIDE);
      end else begin
         w_eff = SW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = SW'(1);
      end else if (32'(height_ff) > 32'(MAX_SIDE)) begin
         h_eff = SW'(MAX_SIDE);
      end else begin
         h_eff = SW'(height_ff);
      end
      if (bpp_ff == '0) begin
         b_eff = BPP_W'(1);
      end else if (bpp_ff > BPP_MAX) begin
         b_eff = BPP_MAX;
      end else begin
         b_eff = bpp_ff;
      end
   end

   assign w_m1     = XW'(w_eff - SW'(1));
   assign h_m1     = XW'(h_eff - SW'(1));
   assign last_col = (col_ff == w_m1);
   assign last     = last_col && (row_ff == h_m1);
   assign accept   = push && !q_full;

   // offset index = fa * fb + fc
   always_comb begin
      entry.pixel  = pixel_in;
      entry.bpp    = b_eff;
      entry.last   = last;
      entry.status = STATUS_OK;
      unique case (rot_ff)
         ROT_90: begin
            entry.fa = col_ff;
            entry.fb = h_eff;
            entry.fc = h_m1 - row_ff;
         end
         ROT_180: begin
            entry.fa = h_m1 - row_ff;
            entry.fb = w_eff;
            entry.fc = w_m1 - col_ff;
         end
         ROT_270: begin
            entry.fa = w_m1 - col_ff;
            entry.fb = h_eff;
            entry.fc = row_ff;
         end
         ROT_NONE: begin
            entry.fa     = '0;
            entry.fb     = '0;
            entry.fc     = '0;
            entry.status = STATUS_UNSUPPORTED;
         end
         default: begin
            entry.fa     = '0;
            entry.fb     = '0;
            entry.fc     = '0;
            entry.status = STATUS_UNSUPPORTED;
         end
      endcase
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_we) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last) begin
            col_in = '0;
            row_in = '0;
         end else if (last_col) begin
            col_in = '0;
            row_in = row_ff + XW'(1);
         end else begin
            col_in = col_ff + XW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         rot_ff    <= ROT_90;
         bpp_ff    <= BPP_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_IMAGE_WIDTH:     width_ff  <= csr_wdata;
               REG_IMAGE_HEIGHT:    height_ff <= csr_wdata;
               REG_ROTATION_MODE:   rot_ff    <= csr_wdata[ROT_W-1:0];
               REG_BYTES_PER_PIXEL: bpp_ff    <= csr_wdata[BPP_W-1:0];
               default:             width_ff  <= width_ff;
            endcase
         end
      end
   end

   assign q_push = accept;
   assign q_data = entry;

   `IRAG_ASSERT(a_front_pos_in_image, clock, reset, (col_ff <= w_m1) && (row_ff <= h_m1), "raster position outside image")

endmodule

`default_nettype wire

// ===== rtl/irag_back.sv =====
// back end: multiply, add and byte scaling of the rotated pixel index
// depends on irag_pkg; drains the middle queue into the result queue
`default_nettype none
`include "image_rotate_address_generator_core_defines.svh"

module irag_back #(
   parameter  int MAX_SIDE = 4096,
   localparam int XW       = $clog2(MAX_SIDE),
   localparam int SW       = $clog2(MAX_SIDE + 1),
   localparam int ENTRY_W  = irag_pkg::PIXEL_W + 2 * XW + SW + irag_pkg::BPP_W + 2
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [ENTRY_W-1:0]             q_data,
   input  wire logic                           q_empty,
   output logic                                q_pop,
   input  wire logic [irag_pkg::OUT_CNT_W-1:0] out_count,
   output logic                                out_push,
   output irag_pkg::rsp_item_type              out_data
);

   import irag_pkg::*;

   localparam int CRW = OUT_CNT_W + 1;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic [XW-1:0]      fa;
      logic [SW-1:0]      fb;
      logic [XW-1:0]      fc;
      logic [BPP_W-1:0]   bpp;
      logic               last;
      logic               status;
   } entry_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] prod;
      logic [XW-1:0]       fc;
      logic [PIXEL_W-1:0]  pixel;
      logic [BPP_W-1:0]    bpp;
      logic                last;
      logic                status;
   } mul_stage_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] idx;
      logic [PIXEL_W-1:0]  pixel;
      logic [BPP_W-1:0]    bpp;
      logic                last;
      logic                status;
   } add_stage_type;

   entry_type            q_item;
   logic [CRW-1:0]       credit_used;
   logic                 issue;
   logic [XW+SW-1:0]     mul_full;
   mul_stage_type        s1_in;
   mul_stage_type        s1_ff;
   logic                 v1_ff;
   add_stage_type        s2_in;
   add_stage_type        s2_ff;
   logic                 v2_ff;
   logic [OFFSET_W-1:0]  scaled;

   assign q_item = q_data;

   // result queue slots held by queued and in-flight items
   assign credit_used = CRW'(out_count) + CRW'(v1_ff) + CRW'(v2_ff);
   assign issue       = !q_empty && (credit_used < CRW'(OUT_DEPTH));
   assign q_pop       = issue;

   assign mul_full     = q_item.fa * q_item.fb;
   assign s1_in.prod   = OFFSET_W'(mul_full);
   assign s1_in.fc     = q_item.fc;
   assign s1_in.pixel  = q_item.pixel;
   assign s1_in.bpp    = q_item.bpp;
   assign s1_in.last   = q_item.last;
   assign s1_in.status = q_item.status;

   assign s2_in.idx    = s1_ff.prod + OFFSET_W'(s1_ff.fc);
   assign s2_in.pixel  = s1_ff.pixel;
   assign s2_in.bpp    = s1_ff.bpp;
   assign s2_in.last   = s1_ff.last;
   assign s2_in.status = s1_ff.status;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

   // bytes per pixel is 1..4 here
   always_comb begin
      case (s2_ff.bpp)
         3'd2:    scaled = s2_ff.idx << 1;
         3'd3:    scaled = (s2_ff.idx << 1) + s2_ff.idx;
         3'd4:    scaled = s2_ff.idx << 2;
         default: scaled = s2_ff.idx;
      endcase
   end

   assign out_push             = v2_ff;
   assign out_data.dest_offset = scaled;
   assign out_data.pixel_out   = s2_ff.pixel;
   assign out_data.last_pixel  = s2_ff.last;
   assign out_data.status      = s2_ff.status;

   `IRAG_ASSERT(a_back_credit, clock, reset, credit_used <= CRW'(OUT_DEPTH), "result queue overcommitted")
   `IRAG_ASSERT(a_back_advance, clock, reset, v1_ff |=> v2_ff, "item lost between stages")
   `IRAG_ASSERT(a_back_unsupported_zero, clock, reset, (v2_ff && s2_ff.status == STATUS_UNSUPPORTED) |-> (scaled == '0), "unsupported mode gave nonzero offset")

endmodule

`default_nettype wire
